/* sv/lcnc_pkg.sv */
// Shared types, constants and helpers for the card number classifier.
// No dependencies; imported by every module of the block.
package lcnc_pkg;

   localparam int CardWidth  = 54;
   localparam int DigitWidth = 4;
   localparam int BcdDigits  = 17;
   localparam int BcdWidth   = BcdDigits * DigitWidth;
   localparam int CntWidth   = $clog2(CardWidth);

   typedef enum logic [1:0] {
      CLS_INVALID = 2'd0,
      CLS_P4      = 2'd1,
      CLS_P3X     = 2'd2,
      CLS_P5X     = 2'd3
   } class_type;

   typedef enum logic [1:0] {
      ST_IDLE,
      ST_CONVERT,
      ST_SUM,
      ST_DONE
   } state_type;

   // control from the sequencer to the decimal shift register
   typedef struct packed {
      logic load;
      logic convert;
      logic shift_digit;
   } bcd_ctl_type;

   function automatic logic [DigitWidth-1:0] bcd_digit(
      input logic [BcdWidth-1:0] bcd,
      input int                  idx
   );
      bcd_digit = bcd[idx*DigitWidth +: DigitWidth];
   endfunction

   // Prefix/length class from the decimal digits (digit 0 is least significant).
   // Every class needs digit 16 to be zero, so 17-digit values fall out.
   function automatic class_type prefix_class(input logic [BcdWidth-1:0] bcd);
      logic [DigitWidth-1:0] d16, d15, d14, d13, d12;
      d16 = bcd_digit(bcd, 16);
      d15 = bcd_digit(bcd, 15);
      d14 = bcd_digit(bcd, 14);
      d13 = bcd_digit(bcd, 13);
      d12 = bcd_digit(bcd, 12);
      prefix_class = CLS_INVALID;
      if (d16 == 4'd0 && d15 == 4'd4) begin
         prefix_class = CLS_P4;
      end else if (d16 == 4'd0 && d15 == 4'd0 && d14 == 4'd0 && d13 == 4'd0
                   && d12 == 4'd4) begin
         prefix_class = CLS_P4;
      end else if (d16 == 4'd0 && d15 == 4'd0 && d14 == 4'd3
                   && (d13 == 4'd4 || d13 == 4'd7)) begin
         prefix_class = CLS_P3X;
      end else if (d16 == 4'd0 && d15 == 4'd5 && d14 >= 4'd1 && d14 <= 4'd5) begin
         prefix_class = CLS_P5X;
      end
   endfunction

endpackage

/* sv/luhn_card_number_classifier.sv */
// Steps from request accept to result valid: operand load on the accept edge,
// 54 convert steps of one bit each, 17 Luhn digit steps, 1 result load, held
// while the result slot is full. One request at a time: the bit-serial converter
// is the shared unit and a new request is taken once the result is parked.
// Reset (synchronous, active high) clears the sequencer and the result valid.
// Top level of the Luhn card number classifier; uses lcnc_pkg,
// lcnc_bin2bcd and lcnc_luhn_acc.
module luhn_card_number_classifier (
   input  logic                           clock,
   input  logic                           reset,
   input  logic                           req_valid,
   output logic                           req_stall,
   input  logic [lcnc_pkg::CardWidth-1:0] req_card_value,
   output logic                           rsp_valid,
   input  logic                           rsp_stall,
   output logic                           rsp_checksum_ok,
   output logic [1:0]                     rsp_issuer_class
);
   import lcnc_pkg::*;

   // sequencer
   state_type             state_ff, state_in;
   logic [CntWidth-1:0]   cnt_ff, cnt_in;
   bcd_ctl_type           bcd_ctl;
   logic                  req_take;
   logic                  rsp_free;
   logic                  acc_clear;
   logic                  acc_step;
   logic                  cls_capture;

   // datapath
   logic [BcdWidth-1:0]   bcd;
   logic [DigitWidth-1:0] low_digit;
   logic                  sum_zero;
   class_type             cls_ff, cls_in;

   // result register
   logic                  rsp_valid_ff, rsp_valid_in;
   logic                  rsp_ok_ff, rsp_ok_in;
   class_type             rsp_cls_ff, rsp_cls_in;

   assign req_take = req_valid && !req_stall;
   // result slot can take a new result when empty or being drained
   assign rsp_free = !rsp_valid_ff || !rsp_stall;

   // next state
   always_comb begin
      state_in = state_ff;
      cnt_in   = cnt_ff;
      unique case (state_ff)
         ST_IDLE: begin
            if (req_valid) begin
               state_in = ST_CONVERT;
               cnt_in   = '0;
            end
         end
         ST_CONVERT: begin
            if (cnt_ff == CntWidth'(CardWidth - 1)) begin
               state_in = ST_SUM;
               cnt_in   = '0;
            end else begin
               cnt_in = cnt_ff + 1'b1;
            end
         end
         ST_SUM: begin
            if (cnt_ff == CntWidth'(BcdDigits - 1)) begin
               state_in = ST_DONE;
               cnt_in   = '0;
            end else begin
               cnt_in = cnt_ff + 1'b1;
            end
         end
         ST_DONE: begin
            if (rsp_free) begin
               state_in = ST_IDLE;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   // outputs of the sequencer
   always_comb begin
      req_stall           = 1'b1;
      bcd_ctl             = '0;
      acc_clear           = 1'b0;
      acc_step            = 1'b0;
      cls_capture         = 1'b0;
      unique case (state_ff)
         ST_IDLE: begin
            req_stall    = 1'b0;
            bcd_ctl.load = req_valid;
            acc_clear    = req_valid;
         end
         ST_CONVERT: begin
            bcd_ctl.convert = 1'b1;
         end
         ST_SUM: begin
            // digits are complete on the first sum cycle, grab the prefix class
            cls_capture         = (cnt_ff == '0);
            bcd_ctl.shift_digit = 1'b1;
            acc_step            = 1'b1;
         end
         ST_DONE: begin
         end
         default: begin
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_IDLE;
         cnt_ff   <= '0;
      end else begin
         state_ff <= state_in;
         cnt_ff   <= cnt_in;
      end
   end

   lcnc_bin2bcd u_bin2bcd (
      .clock     (clock),
      .ctl       (bcd_ctl),
      .bin_value (req_card_value),
      .bcd       (bcd),
      .low_digit (low_digit)
   );

   lcnc_luhn_acc u_luhn_acc (
      .clock    (clock),
      .clear    (acc_clear),
      .step     (acc_step),
      .digit    (low_digit),
      .sum_zero (sum_zero)
   );

   assign cls_in = cls_capture ? prefix_class(bcd) : cls_ff;

   // result register: loads in DONE, clears when the result is taken
   always_comb begin
      rsp_valid_in = rsp_valid_ff;
      rsp_ok_in    = rsp_ok_ff;
      rsp_cls_in   = rsp_cls_ff;
      if (rsp_valid_ff && !rsp_stall) begin
         rsp_valid_in = 1'b0;
      end
      if (state_ff == ST_DONE && rsp_free) begin
         rsp_valid_in = 1'b1;
         rsp_ok_in    = sum_zero;
         // a failed check forces the invalid class
         rsp_cls_in   = sum_zero ? cls_ff : CLS_INVALID;
      end
   end

   always_ff @(posedge clock) begin
      cls_ff     <= cls_in;
      rsp_ok_ff  <= rsp_ok_in;
      rsp_cls_ff <= rsp_cls_in;
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else begin
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   assign rsp_valid        = rsp_valid_ff;
   assign rsp_checksum_ok  = rsp_ok_ff;
   assign rsp_issuer_class = rsp_cls_ff;

   // an accepted request always starts a fresh conversion
   a_accept_starts: assert property (@(posedge clock) disable iff (reset)
      req_take |=> (state_ff == ST_CONVERT && cnt_ff == '0))
      else $error("accepted request did not start conversion");

   // a new result only appears out of the DONE state
   a_rsp_from_done: assert property (@(posedge clock) disable iff (reset)
      $rose(rsp_valid) |-> $past(state_ff) == ST_DONE)
      else $error("result raised outside DONE");

   // a real issuer class implies a passing checksum
   a_class_needs_ok: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && rsp_issuer_class != 2'(CLS_INVALID)) |-> rsp_checksum_ok)
      else $error("issuer class given with failed checksum");

   // bit counter stays within the conversion length
   a_cnt_range: assert property (@(posedge clock) disable iff (reset)
      state_ff == ST_CONVERT |-> cnt_ff <= CntWidth'(CardWidth - 1))
      else $error("conversion counter overran");

endmodule

/* sv/lcnc_bin2bcd.sv */
// Bit-serial binary to decimal converter (shift-and-add-3), then a digit
// shifter that hands out one decimal digit per cycle. Depends on lcnc_pkg.
module lcnc_bin2bcd (
   input  logic                               clock,
   input  lcnc_pkg::bcd_ctl_type              ctl,
   input  logic [lcnc_pkg::CardWidth-1:0]     bin_value,
   output logic [lcnc_pkg::BcdWidth-1:0]      bcd,
   output logic [lcnc_pkg::DigitWidth-1:0]    low_digit
);
   import lcnc_pkg::*;

   logic [CardWidth-1:0] bin_ff, bin_in;
   logic [BcdWidth-1:0]  bcd_ff, bcd_in;
   logic [BcdWidth-1:0]  adj;

   always_comb begin
      for (int i = 0; i < BcdDigits; i++) begin
         if (bcd_ff[i*DigitWidth +: DigitWidth] >= 4'd5) begin
            adj[i*DigitWidth +: DigitWidth] = bcd_ff[i*DigitWidth +: DigitWidth] + 4'd3;
         end else begin
            adj[i*DigitWidth +: DigitWidth] = bcd_ff[i*DigitWidth +: DigitWidth];
         end
      end
   end

   always_comb begin
      bin_in = bin_ff;
      bcd_in = bcd_ff;
      if (ctl.load) begin
         bin_in = bin_value;
         bcd_in = '0;
      end else if (ctl.convert) begin
         bin_in = {bin_ff[CardWidth-2:0], 1'b0};
         bcd_in = {adj[BcdWidth-2:0], bin_ff[CardWidth-1]};
      end else if (ctl.shift_digit) begin
         bcd_in = {{DigitWidth{1'b0}}, bcd_ff[BcdWidth-1:DigitWidth]};
      end
   end

   always_ff @(posedge clock) begin
      bin_ff <= bin_in;
      bcd_ff <= bcd_in;
   end

   assign bcd       = bcd_ff;
   assign low_digit = bcd_ff[DigitWidth-1:0];

endmodule

/* sv/lcnc_luhn_acc.sv */
// Luhn digit accumulator, mod 10, one digit per cycle from the right.
// Depends on lcnc_pkg.
module lcnc_luhn_acc (
   input  logic                             clock,
   input  logic                             clear,
   input  logic                             step,
   input  logic [lcnc_pkg::DigitWidth-1:0]  digit,
   output logic                             sum_zero
);
   import lcnc_pkg::*;

   logic [3:0] acc_ff, acc_in;
   logic       odd_ff, odd_in;
   logic [4:0] dbl;
   logic [3:0] term;
   logic [4:0] total;

   always_comb begin
      dbl = {digit, 1'b0};
      if (!odd_ff) begin
         term = digit;
      end else if (dbl >= 5'd10) begin
         term = 4'(dbl - 5'd9);
      end else begin
         term = dbl[3:0];
      end
      total = {1'b0, acc_ff} + {1'b0, term};
   end

   always_comb begin
      acc_in = acc_ff;
      odd_in = odd_ff;
      if (clear) begin
         acc_in = 4'd0;
         odd_in = 1'b0;
      end else if (step) begin
         acc_in = (total >= 5'd10) ? 4'(total - 5'd10) : total[3:0];
         odd_in = !odd_ff;
      end
   end

   always_ff @(posedge clock) begin
      acc_ff <= acc_in;
      odd_ff <= odd_in;
   end

   assign sum_zero = (acc_ff == 4'd0);

endmodule
